>>> src/particle_pair_collision_response_defines.svh
// Assertion macros for the particle pair collision response block
`ifndef PARTICLE_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`define PARTICLE_PAIR_COLLISION_RESPONSE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define PPCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define PPCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ppcr_pkg.sv
// Types and constants of the particle pair collision response block
package ppcr_pkg;

  // Reset value of the friction register, 0.5 in Q1.16
  localparam logic [16:0] FRICTION_RESET = 17'd32768;

  // Result bits of the square root, fraction bits of the normal and of inverse mass and friction
  localparam int SQ_N = 26;
  localparam int N_SH = 24;
  localparam int Q_SH = 16;

  typedef struct packed {
    logic signed [31:0] a_cur_x;
    logic signed [31:0] a_cur_y;
    logic signed [31:0] a_prev_x;
    logic signed [31:0] a_prev_y;
    logic [23:0]        a_radius;
    logic [23:0]        a_inv_mass;
    logic signed [31:0] b_cur_x;
    logic signed [31:0] b_cur_y;
    logic signed [31:0] b_prev_x;
    logic signed [31:0] b_prev_y;
    logic [23:0]        b_radius;
    logic [23:0]        b_inv_mass;
  } ppcr_in_t;

  typedef struct packed {
    logic signed [31:0] a_new_x;
    logic signed [31:0] a_new_y;
    logic signed [31:0] b_new_x;
    logic signed [31:0] b_new_y;
    logic               collided;
  } ppcr_out_t;

  // Pair context through the distance and square root stages
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] apx;
    logic signed [31:0] apy;
    logic signed [31:0] bpx;
    logic signed [31:0] bpy;
    logic [23:0]        ai;
    logic [23:0]        bi;
    logic [24:0]        r;
    logic signed [26:0] dx;
    logic signed [26:0] dy;
    logic               hit;
  } ppcr_ctx_t;

  // Context carried through the normal dividers
  typedef struct packed {
    ppcr_ctx_t   ctx;
    logic [24:0] depth;
  } ppcr_mid_t;

  // Working set of the push and friction stages
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] apx;
    logic signed [31:0] apy;
    logic signed [31:0] bpx;
    logic signed [31:0] bpy;
    logic [23:0]        ai;
    logic [23:0]        bi;
    logic               hit;
    logic [24:0]        depth;
    logic signed [25:0] nx;
    logic signed [25:0] ny;
    logic [33:0]        pa;
    logic [33:0]        pb;
    logic signed [34:0] pax;
    logic signed [34:0] pay;
    logic signed [34:0] pbx;
    logic signed [34:0] pby;
    logic signed [35:0] axp;
    logic signed [35:0] ayp;
    logic signed [35:0] bxp;
    logic signed [35:0] byp;
    logic signed [37:0] vx;
    logic signed [37:0] vy;
    logic signed [63:0] vnx;
    logic signed [63:0] vny;
    logic signed [38:0] dot;
    logic signed [64:0] dnx;
    logic signed [64:0] dny;
    logic signed [39:0] tx;
    logic signed [39:0] ty;
    logic signed [40:0] fx;
    logic signed [40:0] fy;
  } ppcr_wk_t;

  // Context carried through the friction dividers
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [35:0] axp;
    logic signed [35:0] ayp;
    logic signed [35:0] bxp;
    logic signed [35:0] byp;
    logic               hit;
    logic               fx_neg;
  } ppcr_tail_t;

endpackage

>>> src/ppcr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data
module ppcr_div #(
  parameter int NW = 51,
  parameter int DW = 26,
  parameter int QW = 25,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int EW = DW + QW;

  logic [QW:0]   vld_r;
  logic [NW-1:0] rem_r   [0:QW-1];
  logic [NW-1:0] rem_nxt [0:QW-1];
  logic [DW-1:0] den_r   [0:QW-1];
  logic [QW-1:0] quo_r   [0:QW];
  logic [QW-1:0] quo_nxt [0:QW-1];
  logic [SW-1:0] side_r  [0:QW];

  // Try the shifted divisor against each stage's remainder
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      rem_nxt[j] = rem_r[j];
      quo_nxt[j] = quo_r[j];
      if (EW'(rem_r[j]) >= (EW'(den_r[j]) << (QW - 1 - j))) begin
        rem_nxt[j] = NW'(EW'(rem_r[j]) - (EW'(den_r[j]) << (QW - 1 - j)));
        quo_nxt[j][QW - 1 - j] = 1'b1;
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-1:0], in_v};
    end
  end

  // Advance the stage payload
  always_ff @(posedge clk) begin
    rem_r[0]  <= in_num;
    den_r[0]  <= in_den;
    quo_r[0]  <= '0;
    side_r[0] <= in_side;
    for (int j = 0; j < QW - 1; j++) begin
      rem_r[j+1] <= rem_nxt[j];
      den_r[j+1] <= den_r[j];
    end
    for (int j = 0; j < QW; j++) begin
      quo_r[j+1]  <= quo_nxt[j];
      side_r[j+1] <= side_r[j];
    end
  end

  assign out_v    = vld_r[QW];
  assign out_quo  = quo_r[QW];
  assign out_side = side_r[QW];

endmodule

>>> src/particle_pair_collision_response.sv
// Collision response for a pair of circular Verlet particles
// Throughput: one request per cycle; busy stays low, every stage moves each cycle.
// Depth is set by the 26-stage square root, the 25-bit normal dividers and the
// 41-bit friction dividers, each resolving one bit per stage.
// Reset: synchronous rst_n clears all valid bits and loads friction with 0.5.
`include "particle_pair_collision_response_defines.svh"
module particle_pair_collision_response
  import ppcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ppcr_in_t    in_data,
  output logic        out_valid,
  output ppcr_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int PN = 9;

  // Round a signed value shifted right, half away from zero
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input logic [6:0] sh);
    logic [65:0] m;
    logic [65:0] q;
    m = v[65] ? 66'(-v) : 66'(v);
    q = (m + (66'd1 << (sh - 7'd1))) >> sh;
    return v[65] ? -$signed(q) : $signed(q);
  endfunction

  // Clamp to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      return 32'h7fffffff;
    end else if (v < -43'sd2147483648) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic [16:0] fric_r;

  logic       in_v_r;
  ppcr_in_t   in_r;
  logic       c1_v_r;
  ppcr_ctx_t  c1_r;
  ppcr_ctx_t  c1_nxt;
  logic       c2_v_r;
  ppcr_ctx_t  c2_r;
  logic [50:0] dxx_r;
  logic [50:0] dyy_r;
  logic [49:0] rr_r;
  logic signed [53:0] sq_dx;
  logic signed [53:0] sq_dy;

  logic [SQ_N:0]    sq_v_r;
  logic [51:0]      sq_val_r  [0:SQ_N];
  logic [SQ_N+1:0]  sq_rem_r  [0:SQ_N];
  logic [SQ_N-1:0]  sq_root_r [0:SQ_N];
  ppcr_ctx_t        sq_ctx_r  [0:SQ_N];
  logic [51:0]      sq_val_nxt  [0:SQ_N-1];
  logic [SQ_N+1:0]  sq_rem_nxt  [0:SQ_N-1];
  logic [SQ_N-1:0]  sq_root_nxt [0:SQ_N-1];
  logic [51:0]      d2;
  ppcr_ctx_t        c3;

  ppcr_ctx_t   dc;
  logic [25:0] dd;
  logic [24:0] depth;
  logic [26:0] mdx;
  logic [26:0] mdy;
  logic [50:0] num_x;
  logic [50:0] num_y;
  ppcr_mid_t   mid_in;
  ppcr_mid_t   mid_out;

  logic        dvx_v;
  logic        dvy_v;
  logic [24:0] dvx_q;
  logic [24:0] dvy_q;
  logic [$bits(ppcr_mid_t)-1:0] dvx_side;
  logic        dvy_side;

  logic [PN:0] pv_r;
  ppcr_wk_t    p_r   [0:PN];
  ppcr_wk_t    p_nxt [0:PN];

  ppcr_wk_t    pf;
  ppcr_tail_t  tail_in;
  ppcr_tail_t  tail_out;
  logic [39:0] mfx;
  logic [39:0] mfy;
  logic [24:0] isum;
  logic [63:0] fm_ax;
  logic [63:0] fm_ay;
  logic [63:0] fm_bx;
  logic [63:0] fm_by;
  logic        fax_v;
  logic        fay_v;
  logic        fbx_v;
  logic        fby_v;
  logic [40:0] fax_q;
  logic [40:0] fay_q;
  logic [40:0] fbx_q;
  logic [40:0] fby_q;
  logic [$bits(ppcr_tail_t)-1:0] fax_side;
  logic        fay_side;
  logic        fbx_side;
  logic        fby_side;

  logic signed [42:0] qax;
  logic signed [42:0] qay;
  logic signed [42:0] qbx;
  logic signed [42:0] qby;
  ppcr_out_t   out_nxt;
  logic        out_valid_r;
  ppcr_out_t   out_data_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold the friction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fric_r <= FRICTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fric_r <= cfg_data;
    end
  end

  // Advance the front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      sq_v_r <= '0;
    end else begin
      in_v_r <= start && !busy;
      c1_v_r <= in_v_r;
      c2_v_r <= c1_v_r;
      sq_v_r <= {sq_v_r[SQ_N-1:0], c2_v_r};
    end
  end

  // Find the radius sum, the center gap and the coarse rejects
  always_comb begin
    logic signed [32:0] gx;
    logic signed [32:0] gy;
    logic signed [32:0] rs;
    logic [24:0]        rsum;
    logic               far;
    rsum = 25'(in_r.a_radius) + 25'(in_r.b_radius);
    gx   = 33'(in_r.a_cur_x) - 33'(in_r.b_cur_x);
    gy   = 33'(in_r.a_cur_y) - 33'(in_r.b_cur_y);
    rs   = $signed({8'b0, rsum});
    far  = (gx > rs) || (gx < -rs) || (gy > rs) || (gy < -rs);
    c1_nxt.ax  = in_r.a_cur_x;
    c1_nxt.ay  = in_r.a_cur_y;
    c1_nxt.bx  = in_r.b_cur_x;
    c1_nxt.by  = in_r.b_cur_y;
    c1_nxt.apx = in_r.a_prev_x;
    c1_nxt.apy = in_r.a_prev_y;
    c1_nxt.bpx = in_r.b_prev_x;
    c1_nxt.bpy = in_r.b_prev_y;
    c1_nxt.ai  = in_r.a_inv_mass;
    c1_nxt.bi  = in_r.b_inv_mass;
    c1_nxt.r   = rsum;
    c1_nxt.dx  = $signed(gx[26:0]);
    c1_nxt.dy  = $signed(gy[26:0]);
    c1_nxt.hit = !(in_r.a_inv_mass == 24'd0 && in_r.b_inv_mass == 24'd0) && !far;
  end

  // Square the gaps; the radius sum is squared where the front payload advances
  always_comb begin
    sq_dx = c1_r.dx * c1_r.dx;
    sq_dy = c1_r.dy * c1_r.dy;
  end

  // Sum the squared distance and test for overlap
  always_comb begin
    d2     = 52'(dxx_r) + 52'(dyy_r);
    c3     = c2_r;
    c3.hit = c2_r.hit && (d2 != 52'd0) && (d2 <= 52'(rr_r));
  end

  // Resolve one root bit per square root stage
  always_comb begin
    logic [SQ_N+3:0] rsh;
    logic [SQ_N+3:0] trial;
    for (int k = 0; k < SQ_N; k++) begin
      rsh   = {sq_rem_r[k], sq_val_r[k][51:50]};
      trial = (SQ_N + 4)'({sq_root_r[k], 2'b01});
      sq_val_nxt[k] = {sq_val_r[k][49:0], 2'b00};
      if (rsh >= trial) begin
        sq_rem_nxt[k]  = (SQ_N + 2)'(rsh - trial);
        sq_root_nxt[k] = {sq_root_r[k][SQ_N-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = (SQ_N + 2)'(rsh);
        sq_root_nxt[k] = {sq_root_r[k][SQ_N-2:0], 1'b0};
      end
    end
  end

  // Advance the front payload
  always_ff @(posedge clk) begin
    in_r  <= in_data;
    c1_r  <= c1_nxt;
    c2_r  <= c1_r;
    dxx_r <= sq_dx[50:0];
    dyy_r <= sq_dy[50:0];
    rr_r  <= c1_r.r * c1_r.r;
    sq_val_r[0]  <= d2;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_ctx_r[0]  <= c3;
    for (int k = 0; k < SQ_N; k++) begin
      sq_val_r[k+1]  <= sq_val_nxt[k];
      sq_rem_r[k+1]  <= sq_rem_nxt[k];
      sq_root_r[k+1] <= sq_root_nxt[k];
      sq_ctx_r[k+1]  <= sq_ctx_r[k];
    end
  end

  // Form depth and the rounded normal numerators
  always_comb begin
    dc    = sq_ctx_r[SQ_N];
    dd    = sq_root_r[SQ_N];
    depth = 25'(26'({1'b0, dc.r}) - dd);
    mdx   = dc.dx[26] ? 27'(-dc.dx) : 27'(dc.dx);
    mdy   = dc.dy[26] ? 27'(-dc.dy) : 27'(dc.dy);
    num_x = {mdx, 24'b0} + 51'(dd[25:1]);
    num_y = {mdy, 24'b0} + 51'(dd[25:1]);
    mid_in.ctx   = dc;
    mid_in.depth = depth;
  end

  ppcr_div #(.NW(51), .DW(26), .QW(25), .SW($bits(ppcr_mid_t))) u_div_nx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (sq_v_r[SQ_N]),
    .in_num   (num_x),
    .in_den   (dd),
    .in_side  (mid_in),
    .out_v    (dvx_v),
    .out_quo  (dvx_q),
    .out_side (dvx_side)
  );

  ppcr_div #(.NW(51), .DW(26), .QW(25), .SW(1)) u_div_ny (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (sq_v_r[SQ_N]),
    .in_num   (num_y),
    .in_den   (dd),
    .in_side  (dc.dy[26]),
    .out_v    (dvy_v),
    .out_quo  (dvy_q),
    .out_side (dvy_side)
  );

  assign mid_out = ppcr_mid_t'(dvx_side);

  // Push apart along the normal, then find the tangential friction term
  always_comb begin
    logic signed [65:0] pm [0:3];
    logic signed [65:0] rd [0:3];
    logic [48:0]        pw_a;
    logic [48:0]        pw_b;

    // enter with the signed normal
    p_nxt[0]       = '0;
    p_nxt[0].ax    = mid_out.ctx.ax;
    p_nxt[0].ay    = mid_out.ctx.ay;
    p_nxt[0].bx    = mid_out.ctx.bx;
    p_nxt[0].by    = mid_out.ctx.by;
    p_nxt[0].apx   = mid_out.ctx.apx;
    p_nxt[0].apy   = mid_out.ctx.apy;
    p_nxt[0].bpx   = mid_out.ctx.bpx;
    p_nxt[0].bpy   = mid_out.ctx.bpy;
    p_nxt[0].ai    = mid_out.ctx.ai;
    p_nxt[0].bi    = mid_out.ctx.bi;
    p_nxt[0].hit   = mid_out.ctx.hit;
    p_nxt[0].depth = mid_out.depth;
    p_nxt[0].nx    = mid_out.ctx.dx[26] ? -26'(dvx_q) : 26'(dvx_q);
    p_nxt[0].ny    = dvy_side ? -26'(dvy_q) : 26'(dvy_q);

    // push lengths of each particle
    pw_a        = p_r[0].depth * p_r[0].ai;
    pw_b        = p_r[0].depth * p_r[0].bi;
    p_nxt[1]    = p_r[0];
    p_nxt[1].pa = 34'((pw_a + 49'd32768) >> Q_SH);
    p_nxt[1].pb = 34'((pw_b + 49'd32768) >> Q_SH);

    // push components
    pm[0] = $signed({1'b0, p_r[1].pa}) * p_r[1].nx;
    pm[1] = $signed({1'b0, p_r[1].pa}) * p_r[1].ny;
    pm[2] = $signed({1'b0, p_r[1].pb}) * p_r[1].nx;
    pm[3] = $signed({1'b0, p_r[1].pb}) * p_r[1].ny;
    for (int i = 0; i < 4; i++) begin
      rd[i] = rnd_shr(pm[i], 7'(N_SH));
    end
    p_nxt[2]     = p_r[1];
    p_nxt[2].pax = $signed(rd[0][34:0]);
    p_nxt[2].pay = $signed(rd[1][34:0]);
    p_nxt[2].pbx = $signed(rd[2][34:0]);
    p_nxt[2].pby = $signed(rd[3][34:0]);

    // pushed positions
    p_nxt[3]     = p_r[2];
    p_nxt[3].axp = 36'(p_r[2].ax) + 36'(p_r[2].pax);
    p_nxt[3].ayp = 36'(p_r[2].ay) + 36'(p_r[2].pay);
    p_nxt[3].bxp = 36'(p_r[2].bx) - 36'(p_r[2].pbx);
    p_nxt[3].byp = 36'(p_r[2].by) - 36'(p_r[2].pby);

    // relative velocity
    p_nxt[4]    = p_r[3];
    p_nxt[4].vx = 38'(p_r[3].axp) - 38'(p_r[3].apx) - 38'(p_r[3].bxp) + 38'(p_r[3].bpx);
    p_nxt[4].vy = 38'(p_r[3].ayp) - 38'(p_r[3].apy) - 38'(p_r[3].byp) + 38'(p_r[3].bpy);

    // velocity times normal
    p_nxt[5]     = p_r[4];
    p_nxt[5].vnx = p_r[4].vx * p_r[4].nx;
    p_nxt[5].vny = p_r[4].vy * p_r[4].ny;

    // normal speed
    rd[0]        = rnd_shr(66'(p_r[5].vnx) + 66'(p_r[5].vny), 7'(N_SH));
    p_nxt[6]     = p_r[5];
    p_nxt[6].dot = $signed(rd[0][38:0]);

    // normal velocity components
    p_nxt[7]     = p_r[6];
    p_nxt[7].dnx = p_r[6].dot * p_r[6].nx;
    p_nxt[7].dny = p_r[6].dot * p_r[6].ny;

    // tangential velocity
    rd[0]       = rnd_shr(66'(p_r[7].dnx), 7'(N_SH));
    rd[1]       = rnd_shr(66'(p_r[7].dny), 7'(N_SH));
    p_nxt[8]    = p_r[7];
    p_nxt[8].tx = 40'(p_r[7].vx) - $signed(rd[0][39:0]);
    p_nxt[8].ty = 40'(p_r[7].vy) - $signed(rd[1][39:0]);

    // friction term
    pm[0]       = p_r[8].tx * $signed({1'b0, fric_r});
    pm[1]       = p_r[8].ty * $signed({1'b0, fric_r});
    rd[0]       = rnd_shr(pm[0], 7'(Q_SH));
    rd[1]       = rnd_shr(pm[1], 7'(Q_SH));
    p_nxt[9]    = p_r[8];
    p_nxt[9].fx = $signed(rd[0][40:0]);
    p_nxt[9].fy = $signed(rd[1][40:0]);
  end

  // Advance the push and friction stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[PN-1:0], dvx_v};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= PN; k++) begin
      p_r[k] <= p_nxt[k];
    end
  end

  // Weight the friction term by each inverse mass, rounded numerators
  always_comb begin
    pf    = p_r[PN];
    mfx   = pf.fx[40] ? 40'(-pf.fx) : 40'(pf.fx);
    mfy   = pf.fy[40] ? 40'(-pf.fy) : 40'(pf.fy);
    isum  = 25'(pf.ai) + 25'(pf.bi);
    fm_ax = mfx * pf.ai;
    fm_ay = mfy * pf.ai;
    fm_bx = mfx * pf.bi;
    fm_by = mfy * pf.bi;
    tail_in.ax     = pf.ax;
    tail_in.ay     = pf.ay;
    tail_in.bx     = pf.bx;
    tail_in.by     = pf.by;
    tail_in.axp    = pf.axp;
    tail_in.ayp    = pf.ayp;
    tail_in.bxp    = pf.bxp;
    tail_in.byp    = pf.byp;
    tail_in.hit    = pf.hit;
    tail_in.fx_neg = pf.fx[40];
  end

  ppcr_div #(.NW(65), .DW(25), .QW(41), .SW($bits(ppcr_tail_t))) u_div_fax (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pv_r[PN]),
    .in_num   (65'(fm_ax) + 65'(isum[24:1])),
    .in_den   (isum),
    .in_side  (tail_in),
    .out_v    (fax_v),
    .out_quo  (fax_q),
    .out_side (fax_side)
  );

  ppcr_div #(.NW(65), .DW(25), .QW(41), .SW(1)) u_div_fay (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pv_r[PN]),
    .in_num   (65'(fm_ay) + 65'(isum[24:1])),
    .in_den   (isum),
    .in_side  (pf.fy[40]),
    .out_v    (fay_v),
    .out_quo  (fay_q),
    .out_side (fay_side)
  );

  ppcr_div #(.NW(65), .DW(25), .QW(41), .SW(1)) u_div_fbx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pv_r[PN]),
    .in_num   (65'(fm_bx) + 65'(isum[24:1])),
    .in_den   (isum),
    .in_side  (pf.fx[40]),
    .out_v    (fbx_v),
    .out_quo  (fbx_q),
    .out_side (fbx_side)
  );

  ppcr_div #(.NW(65), .DW(25), .QW(41), .SW(1)) u_div_fby (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pv_r[PN]),
    .in_num   (65'(fm_by) + 65'(isum[24:1])),
    .in_den   (isum),
    .in_side  (pf.fy[40]),
    .out_v    (fby_v),
    .out_quo  (fby_q),
    .out_side (fby_side)
  );

  // Apply friction, saturate, or pass the positions through
  always_comb begin
    tail_out = ppcr_tail_t'(fax_side);
    qax = tail_out.fx_neg ? -43'(fax_q) : 43'(fax_q);
    qay = fay_side ? -43'(fay_q) : 43'(fay_q);
    qbx = fbx_side ? -43'(fbx_q) : 43'(fbx_q);
    qby = fby_side ? -43'(fby_q) : 43'(fby_q);
    if (tail_out.hit) begin
      out_nxt.a_new_x = sat32(43'(tail_out.axp) - qax);
      out_nxt.a_new_y = sat32(43'(tail_out.ayp) - qay);
      out_nxt.b_new_x = sat32(43'(tail_out.bxp) + qbx);
      out_nxt.b_new_y = sat32(43'(tail_out.byp) + qby);
    end else begin
      out_nxt.a_new_x = tail_out.ax;
      out_nxt.a_new_y = tail_out.ay;
      out_nxt.b_new_x = tail_out.bx;
      out_nxt.b_new_y = tail_out.by;
    end
    out_nxt.collided = tail_out.hit;
  end

  // Drive the result strobe and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fax_v;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPCR_ASSERT_IMP(a_nrm_align, dvx_v || dvy_v, dvx_v && dvy_v, "normal dividers out of step")
  `PPCR_ASSERT_IMP(a_fric_align, fax_v, fay_v && fbx_v && fby_v, "friction dividers out of step")
  `PPCR_ASSERT_NXT(a_out_follow, fax_v, out_valid_r, "result strobe lost after friction")

endmodule
